### rtl/char_class_stable_partition_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef CHAR_CLASS_STABLE_PARTITION_MACROS_SVH
`define CHAR_CLASS_STABLE_PARTITION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCSP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CCSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/ccsp_pkg.sv
// ----------------------------------------------------------------------------
// ccsp_pkg
// Types, sizes and the byte classifier of the character-class partitioner.
// ----------------------------------------------------------------------------
package ccsp_pkg;

  parameter int unsigned MAX_LEN = 64;
  parameter int unsigned ADDR_W  = $clog2(MAX_LEN);
  parameter int unsigned CNT_W   = $clog2(MAX_LEN + 1);

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       overflowed;
  } out_item_t;

  // Emission order of the groups.
  typedef enum logic [1:0] {
    GRP_DIGIT  = 2'd0,
    GRP_LETTER = 2'd1,
    GRP_OTHER  = 2'd2
  } group_e;

  typedef enum logic {
    ST_FILL = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  // A result handed from the sequencer to the output register.
  typedef struct packed {
    logic      load;
    out_item_t item;
  } emit_t;

  function automatic group_e byte_group(input logic [7:0] b);
    group_e g;
    if (b >= 8'h30 && b <= 8'h39) begin
      g = GRP_DIGIT;
    end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
      g = GRP_LETTER;
    end else begin
      g = GRP_OTHER;
    end
    return g;
  endfunction

endpackage

### rtl/ccsp_ram.sv
// ----------------------------------------------------------------------------
// ccsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ccsp_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // The read register holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ccsp_ctrl.sv
// ----------------------------------------------------------------------------
// ccsp_ctrl
// Fill counter and three-pass read sequencer around the byte buffer.
// ----------------------------------------------------------------------------
module ccsp_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ccsp_pkg::in_item_t          in_item_i,
  input  logic                        out_free_i,
  output ccsp_pkg::emit_t             emit_o,
  output logic                        we_o,
  output logic [ccsp_pkg::ADDR_W-1:0] waddr_o,
  output logic [7:0]                  wdata_o,
  output logic                        re_o,
  output logic [ccsp_pkg::ADDR_W-1:0] raddr_o,
  input  logic [7:0]                  rdata_i
);

  ccsp_pkg::state_e state_q, state_d;
  logic [ccsp_pkg::CNT_W-1:0]  fill_q, fill_d;
  logic                        drop_q, drop_d;
  logic [ccsp_pkg::ADDR_W-1:0] ri_q, ri_d;
  ccsp_pkg::group_e            rpass_q, rpass_d;
  logic                        rdone_q, rdone_d;
  logic                        pend_q, pend_d;
  ccsp_pkg::group_e            ppass_q, ppass_d;
  logic [ccsp_pkg::CNT_W-1:0]  n_q, n_d;

  logic accept, is_full, match, consume, load, issue, last, finish, wrap;

  assign accept  = in_valid_i && in_ready_o;
  assign is_full = (fill_q == ccsp_pkg::CNT_W'(ccsp_pkg::MAX_LEN));
  assign match   = (ccsp_pkg::byte_group(rdata_i) == ppass_q);
  assign consume = (state_q == ccsp_pkg::ST_EMIT) && pend_q && (!match || out_free_i);
  assign load    = consume && match;
  assign issue   = (state_q == ccsp_pkg::ST_EMIT) && !rdone_q && (!pend_q || consume);
  assign last    = ((n_q + 1'b1) == fill_q);
  assign finish  = load && last;
  assign wrap    = ((ccsp_pkg::CNT_W'(ri_q) + 1'b1) == fill_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ccsp_pkg::ST_FILL: begin
        if (accept && in_item_i.is_end) begin
          state_d = ccsp_pkg::ST_EMIT;
        end
      end
      ccsp_pkg::ST_EMIT: begin
        if (finish) begin
          state_d = ccsp_pkg::ST_FILL;
        end
      end
      default: state_d = ccsp_pkg::ST_FILL;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      ccsp_pkg::ST_FILL: in_ready_o = 1'b1;
      ccsp_pkg::ST_EMIT: in_ready_o = 1'b0;
      default:           in_ready_o = 1'b0;
    endcase
  end

  // Buffer ports.
  assign we_o    = accept && !is_full;
  assign waddr_o = fill_q[ccsp_pkg::ADDR_W-1:0];
  assign wdata_o = in_item_i.char_code;
  assign re_o    = issue;
  assign raddr_o = ri_q;

  assign emit_o.load            = load;
  assign emit_o.item.out_char   = rdata_i;
  assign emit_o.item.out_last   = last;
  assign emit_o.item.overflowed = drop_q;

  // Counters and read sequencing.
  always_comb begin
    fill_d  = fill_q;
    drop_d  = drop_q;
    ri_d    = ri_q;
    rpass_d = rpass_q;
    rdone_d = rdone_q;
    pend_d  = pend_q;
    ppass_d = ppass_q;
    n_d     = n_q;

    if (accept) begin
      if (is_full) begin
        drop_d = 1'b1;
      end else begin
        fill_d = fill_q + 1'b1;
      end
      if (in_item_i.is_end) begin
        ri_d    = '0;
        rpass_d = ccsp_pkg::GRP_DIGIT;
        rdone_d = 1'b0;
        pend_d  = 1'b0;
        n_d     = '0;
      end
    end

    if (consume) begin
      pend_d = 1'b0;
    end
    if (issue) begin
      pend_d  = 1'b1;
      ppass_d = rpass_q;
      if (wrap) begin
        ri_d = '0;
        case (rpass_q)
          ccsp_pkg::GRP_DIGIT:  rpass_d = ccsp_pkg::GRP_LETTER;
          ccsp_pkg::GRP_LETTER: rpass_d = ccsp_pkg::GRP_OTHER;
          default:              rdone_d = 1'b1;
        endcase
      end else begin
        ri_d = ri_q + 1'b1;
      end
    end

    if (load) begin
      n_d = n_q + 1'b1;
    end
    if (finish) begin
      fill_d = '0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccsp_pkg::ST_FILL;
      fill_q  <= '0;
      drop_q  <= 1'b0;
      ri_q    <= '0;
      rpass_q <= ccsp_pkg::GRP_DIGIT;
      rdone_q <= 1'b1;
      pend_q  <= 1'b0;
      ppass_q <= ccsp_pkg::GRP_DIGIT;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      ri_q    <= ri_d;
      rpass_q <= rpass_d;
      rdone_q <= rdone_d;
      pend_q  <= pend_d;
      ppass_q <= ppass_d;
      n_q     <= n_d;
    end
  end

endmodule

### rtl/char_class_stable_partition.sv
// ----------------------------------------------------------------------------
// char_class_stable_partition
// Buffers a byte string and emits it grouped as digits, letters, others.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one byte per item; is_end marks the last byte of
// a string. Input items are taken one per cycle while the string is filled.
// Up to 64 bytes are kept; later bytes are dropped and every result of that
// string then shows overflowed. After the end item the input is held off
// while the buffer is read in three passes, one per class, each pass reading
// every stored byte once through the single read port of the buffer RAM.
// The last result carries out_last. It waits in the output register, and
// the next string may already be taken in while it waits.
// A stalled output register holds its item and the read sequencer waits.
// Reset empties the buffer count and the output register; no clearing pass.
// ----------------------------------------------------------------------------
module char_class_stable_partition (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ccsp_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ccsp_pkg::out_item_t  out_item_o
);

  ccsp_pkg::emit_t              emit;
  logic                         we, re;
  logic [ccsp_pkg::ADDR_W-1:0]  waddr, raddr;
  logic [7:0]                   wdata, rdata;
  logic                         out_free;
  logic                         out_valid_q, out_valid_d;
  ccsp_pkg::out_item_t          out_item_q;

  assign out_free = !out_valid_q || out_ready_i;

  ccsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_free_i (out_free),
    .emit_o     (emit),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  ccsp_ram #(
    .DEPTH (ccsp_pkg::MAX_LEN),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_item_q <= emit.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/ccsp_checker.sv
// ----------------------------------------------------------------------------
// ccsp_checker
// Port-level checks of the character-class partitioner, bound to the top.
// ----------------------------------------------------------------------------
`include "char_class_stable_partition_macros.svh"

module ccsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ccsp_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ccsp_pkg::out_item_t out_item_o
);

  // A stalled result stays in place.
  `CCSP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))

  // The end of a string closes the input while the buffer is read out.
  `CCSP_ASSERT_NEXT(a_end_blocks, in_valid_i && in_ready_o && in_item_i.is_end, !in_ready_o)

  // A result that is not the last one is only shown while input is held off.
  `CCSP_ASSERT_SAME(a_mid_blocks, out_valid_o && !out_item_o.out_last, !in_ready_o)

endmodule

bind char_class_stable_partition ccsp_checker u_ccsp_checker (.*);

### verif/partition_checker.sv
// ----------------------------------------------------------------------------
// partition_checker
// Watches both channels of the character-class partitioner. It predicts the
// grouped byte order of every string and compares each result as it leaves.
// ----------------------------------------------------------------------------
module partition_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ccsp_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ccsp_pkg::out_item_t out_item_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);

  logic [7:0]          stored_chars [ccsp_pkg::MAX_LEN];
  int unsigned         stored_count = 0;
  logic                lost_char = 1'b0;
  ccsp_pkg::out_item_t expected_chars [$];
  int unsigned         mismatches = 0;
  int unsigned         checked = 0;

  assign mismatches_o = mismatches;
  assign checked_o    = checked;

  // Stores one byte and, on the end item, queues the grouped string.
  task automatic partition_string(input ccsp_pkg::in_item_t item);
    ccsp_pkg::group_e    order [3];
    ccsp_pkg::group_e    grp;
    logic [7:0]          folded;
    ccsp_pkg::out_item_t want;
    int unsigned         n;
    order = '{ccsp_pkg::GRP_DIGIT, ccsp_pkg::GRP_LETTER, ccsp_pkg::GRP_OTHER};
    if (stored_count < ccsp_pkg::MAX_LEN) begin
      stored_chars[stored_count] = item.char_code;
      stored_count++;
    end else begin
      lost_char = 1'b1;
    end
    if (item.is_end) begin
      n = 0;
      foreach (order[p]) begin
        for (int unsigned i = 0; i < stored_count; i++) begin
          // Setting bit 5 folds upper case onto lower case.
          folded = stored_chars[i] | 8'h20;
          if (stored_chars[i] >= 8'h30 && stored_chars[i] <= 8'h39) begin
            grp = ccsp_pkg::GRP_DIGIT;
          end else if (folded >= 8'h61 && folded <= 8'h7A) begin
            grp = ccsp_pkg::GRP_LETTER;
          end else begin
            grp = ccsp_pkg::GRP_OTHER;
          end
          if (grp == order[p]) begin
            n++;
            want.out_char   = stored_chars[i];
            want.out_last   = (n == stored_count);
            want.overflowed = lost_char;
            expected_chars.push_back(want);
          end
        end
      end
      stored_count = 0;
      lost_char    = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    ccsp_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d arrived with nothing expected: out_char %h last %b ovf %b",
                     checked, out_item_i.out_char, out_item_i.out_last,
                     out_item_i.overflowed);
          end
        end else begin
          want = expected_chars.pop_front();
          if (out_item_i.out_char !== want.out_char || out_item_i.out_last !== want.out_last
              || out_item_i.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: out_char %h (want %h) out_last %b (want %b) %s %b (want %b)",
                       checked, out_item_i.out_char, want.out_char, out_item_i.out_last,
                       want.out_last, "overflowed", out_item_i.overflowed, want.overflowed);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        partition_string(in_item_i);
      end
    end
    pending_o <= expected_chars.size();
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives byte strings into the character-class partitioner with random gaps
// and output stalls; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned TARGET_BYTES = 330;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  ccsp_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  ccsp_pkg::out_item_t out_item_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  bit          calm = 1'b0;
  logic [7:0]  text_q [$];
  int unsigned bytes_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned long_strings = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;

  char_class_stable_partition DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  partition_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #4;
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
  end

  // Mostly short idle spans, now and then a long one.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = 8'h30 + 8'($urandom_range(0, 9));
      1: c = 8'h41 + 8'($urandom_range(0, 25));
      2: c = 8'h61 + 8'($urandom_range(0, 25));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // Receiver: random stretches of ready and stall, always ready while calm.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
      end else if (calm || $urandom_range(0, 99) < 65) begin
        out_ready_i <= 1'b1;
        hold_left = calm ? 0 : $urandom_range(0, 6);
      end else begin
        out_ready_i <= 1'b0;
        hold_left = idle_span() - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Sends the bytes in text_q as one string, end flag on the last item.
  task automatic send_text();
    ccsp_pkg::in_item_t item;
    int unsigned        gap;
    foreach (text_q[k]) begin
      gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_span();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      item.char_code = text_q[k];
      item.is_end    = (k == text_q.size() - 1);
      in_item_i  <= item;
      in_valid_i <= 1'b1;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      @(negedge clk_i);
      bytes_sent++;
    end
    strings_sent++;
    if (text_q.size() > ccsp_pkg::MAX_LEN) long_strings++;
    text_q.delete();
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned heavy_len [3];
    int unsigned len;
    int unsigned r;
    heavy_len = '{ccsp_pkg::MAX_LEN, ccsp_pkg::MAX_LEN + 1, ccsp_pkg::MAX_LEN + 6};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Class boundaries on both sides of every range, a one-byte string,
    // the zero byte and the all-ones byte.
    text_q = '{8'h41};
    send_text();
    text_q = '{8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41, 8'h5A, 8'h5B};
    send_text();
    text_q = '{8'h60, 8'h61, 8'h7A, 8'h7B, 8'h80, 8'hFF, 8'h01, 8'h00, 8'h35};
    send_text();
    text_q = '{8'h20, 8'h7F};
    send_text();
    text_q = '{8'h31, 8'h30};
    send_text();
    wait_for_results();

    // Exactly full, end item dropped, and several bytes dropped; no idling.
    calm = 1'b1;
    foreach (heavy_len[h]) begin
      repeat (heavy_len[h]) text_q.push_back(pick_char());
      send_text();
    end
    calm = 1'b0;

    while (bytes_sent < TARGET_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 12);
      else if (r < 95) len = $urandom_range(13, 40);
      else len = $urandom_range(ccsp_pkg::MAX_LEN - 4, ccsp_pkg::MAX_LEN + 6);
      repeat (len) text_q.push_back(pick_char());
      send_text();
      if (strings_sent == 12) wait_for_results();
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Sent %0d bytes in %0d strings, %0d longer than the buffer; %0d results checked.",
             bytes_sent, strings_sent, long_strings, checked);
    $display("Covered class edges, zero and 0xFF bytes, full and overflowing strings, stalls.");
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
